/* src/imq_pkg.sv */
// ----------------------------------------------------------------------------
// imq_pkg
// Shared types, widths and codes for the indexed min priority queue.
// ----------------------------------------------------------------------------
package imq_pkg;
    localparam int SLOTS    = 16;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int POS_W    = $clog2(SLOTS + 1);
    localparam int KEY_W    = 32;
    localparam int CMD_W    = 3;
    localparam int STAT_W   = 3;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CHANGE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STAT_W-1:0] ST_PRESENT = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd3;
    localparam logic [STAT_W-1:0] ST_ABSENT  = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic [SLOT_W-1:0]       slot;
        logic signed [KEY_W-1:0] new_key;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0]       removed_slot;
        logic [SLOT_W-1:0]       min_slot;
        logic signed [KEY_W-1:0] min_key;
        logic [POS_W-1:0]        occupancy;
        logic                    is_empty;
        logic [STAT_W-1:0]       status;
        logic                    slot_present;
        logic signed [KEY_W-1:0] slot_key;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request
        logic start_cmd;  // apply command bookkeeping
        logic up_step;    // one sift-up compare/swap
        logic dn_step;    // one sift-down compare/swap
        logic set_dn;     // reload cursor for sift-down
        logic make_rsp;   // build response
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic do_sift;    // command needs sifting
        logic up_more;    // another sift-up step will swap
        logic dn_more;    // another sift-down step will swap
    } t_sts;
endpackage

/* src/imq_if.sv */
// ----------------------------------------------------------------------------
// imq_if
// Valid/ready channel carrying one beat of payload.
// ----------------------------------------------------------------------------
interface imq_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/indexed_min_priority_queue.sv */
// ----------------------------------------------------------------------------
// indexed_min_priority_queue
// Binary min-heap of signed keys indexed by slot number.
// ----------------------------------------------------------------------------
// Usage: one command beat enters on i_req (insert, remove minimum, change
// key, delete slot, query) and exactly one reply beat leaves on o_rsp.
// The reply gives the removed slot, heap minimum, occupancy, status code
// and the named slot's presence and key.
// Sequence: the accept state, the command state, sift-up swaps then a turn,
// sift-down swaps then a finish, and the reply state; an entry moves one
// way only. A new command is taken only once the last one has reached the
// reply state; the single compare/swap unit over the heap registers sets this.
// Reset clears the count and the position map, so the queue starts empty.
// A stalled reply holds in its register; the next command is accepted and
// worked, and its reply waits until the held beat is taken.
// ----------------------------------------------------------------------------
module indexed_min_priority_queue
    import imq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    imq_if.sink   i_req,
    imq_if.source o_rsp
);
    t_ctl w_ctl;
    t_sts w_sts;
    t_rsp w_rsp;

    imq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .o_out_valid(o_rsp.valid),
        .i_out_ready(o_rsp.ready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    imq_dp u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (i_req.data),
        .i_ctl  (w_ctl),
        .o_sts  (w_sts),
        .o_rsp  (w_rsp)
    );

    assign o_rsp.data = w_rsp;
endmodule

/* src/imq_ctrl.sv */
// ----------------------------------------------------------------------------
// imq_ctrl
// Sequencer: accept beat, apply command, sift up then down, emit response.
// ----------------------------------------------------------------------------
module imq_ctrl
    import imq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_ctl o_ctl
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMD  = 3'd1;
    localparam logic [2:0] S_UP   = 3'd2;
    localparam logic [2:0] S_DN   = 3'd3;
    localparam logic [2:0] S_RSP  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_ctl       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ctl.load = i_in_valid;
                if (i_in_valid) n_state = S_CMD;
            end
            S_CMD: begin
                o_ctl.start_cmd = 1'b1;
                n_state = S_UP;
            end
            S_UP: begin
                // status is valid once command bookkeeping is done
                if (i_sts.do_sift && i_sts.up_more) begin
                    o_ctl.up_step = 1'b1;
                end else begin
                    o_ctl.set_dn = 1'b1;
                    n_state = S_DN;
                end
            end
            S_DN: begin
                if (i_sts.do_sift && i_sts.dn_more) o_ctl.dn_step = 1'b1;
                else n_state = S_RSP;
            end
            S_RSP: begin
                // hold until the previous response is gone
                if (!r_out_valid || i_out_ready) begin
                    o_ctl.make_rsp = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ctl.up_step && o_ctl.dn_step)) else $error("up and down step together");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.make_rsp |=> r_out_valid) else $error("response not raised");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |=> r_state == S_CMD) else $error("load did not advance");
endmodule

/* src/imq_dp.sv */
// ----------------------------------------------------------------------------
// imq_dp
// Heap storage, position map, keys and one compare/swap unit.
// ----------------------------------------------------------------------------
module imq_dp
    import imq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_req,
    input  t_ctl i_ctl,
    output t_sts o_sts,
    output t_rsp o_rsp
);
    logic [SLOT_W-1:0]       r_heap [1:SLOTS];
    logic [POS_W-1:0]        r_pos  [SLOTS];
    logic signed [KEY_W-1:0] r_key  [SLOTS];
    logic [POS_W-1:0]        r_cnt;
    t_req                    r_req;
    logic [POS_W-1:0]        r_p;
    logic                    r_sift, n_sift;
    logic [STAT_W-1:0]       r_stat, n_stat;
    logic [SLOT_W-1:0]       r_removed, n_removed;
    t_rsp                    r_rsp;

    function automatic logic signed [KEY_W-1:0] key_at(
        input logic [POS_W-1:0] p,
        input logic [SLOT_W-1:0] h [1:SLOTS],
        input logic signed [KEY_W-1:0] k [SLOTS]);
        logic signed [KEY_W-1:0] v;
        v = '0;
        if (p >= POS_W'(1) && p <= POS_W'(SLOTS)) v = k[h[p]];
        return v;
    endfunction

    // sift-up candidate
    logic [POS_W-1:0] w_par;
    logic             w_up;
    // sift-down candidate
    logic [POS_W:0]   w_c2;
    logic [POS_W-1:0] w_c;
    logic             w_dn;
    logic [POS_W-1:0] w_swp;

    always_comb begin
        w_par = r_p >> 1;
        w_up  = (r_p > POS_W'(1)) && (r_p <= r_cnt) &&
                (key_at(w_par, r_heap, r_key) > key_at(r_p, r_heap, r_key));
        w_c2  = {r_p, 1'b0};
        w_c   = w_c2[POS_W-1:0];
        w_dn  = 1'b0;
        if (r_p >= POS_W'(1) && w_c2 <= {1'b0, r_cnt}) begin
            if (w_c < r_cnt && key_at(w_c, r_heap, r_key) >
                key_at(w_c + POS_W'(1), r_heap, r_key))
                w_c = w_c + POS_W'(1);
            w_dn = key_at(r_p, r_heap, r_key) > key_at(w_c, r_heap, r_key);
        end
        w_swp = i_ctl.up_step ? w_par : w_c;
    end

    assign o_sts.do_sift = r_sift;
    assign o_sts.up_more = w_up;
    assign o_sts.dn_more = w_dn;
    assign o_rsp = r_rsp;

    logic w_pres;
    logic [POS_W-1:0] w_last;
    logic [POS_W-1:0] w_tpos;
    assign w_pres = r_pos[r_req.slot] != '0;
    assign w_last = r_cnt;
    assign w_tpos = (r_req.command == CMD_REMOVE) ? POS_W'(1) : r_pos[r_req.slot];

    // command outcome
    always_comb begin
        n_stat    = ST_OK;
        n_removed = '0;
        n_sift    = 1'b0;
        case (r_req.command)
            CMD_INSERT: begin
                if (r_cnt >= POS_W'(SLOTS)) n_stat = ST_FULL;
                else if (w_pres) n_stat = ST_PRESENT;
                else n_sift = 1'b1;
            end
            CMD_CHANGE: begin
                if (!w_pres) n_stat = ST_ABSENT;
                else n_sift = 1'b1;
            end
            CMD_REMOVE: begin
                if (r_cnt == '0) n_stat = ST_EMPTY;
                else begin
                    n_removed = r_heap[1];
                    n_sift    = w_tpos < w_last;
                end
            end
            CMD_DELETE: begin
                if (!w_pres) n_stat = ST_ABSENT;
                else n_sift = w_tpos < w_last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) r_pos[i] <= '0;
            r_cnt  <= '0;
            r_sift <= 1'b0;
        end else begin
            if (i_ctl.load) r_req <= i_req;
            if (i_ctl.start_cmd) begin
                r_stat    <= n_stat;
                r_removed <= n_removed;
                r_sift    <= n_sift;
                case (r_req.command) inside
                    CMD_INSERT: begin
                        if (n_stat == ST_OK) begin
                            r_cnt <= r_cnt + POS_W'(1);
                            r_pos[r_req.slot] <= r_cnt + POS_W'(1);
                            r_heap[r_cnt + POS_W'(1)] <= r_req.slot;
                            r_key[r_req.slot] <= r_req.new_key;
                            r_p <= r_cnt + POS_W'(1);
                        end
                    end
                    CMD_CHANGE: begin
                        if (n_stat == ST_OK) begin
                            r_key[r_req.slot] <= r_req.new_key;
                            r_p <= r_pos[r_req.slot];
                        end
                    end
                    CMD_REMOVE, CMD_DELETE: begin
                        if (n_stat == ST_OK) begin
                            // move last entry into the hole, drop the target
                            if (w_tpos != w_last) begin
                                r_heap[w_tpos] <= r_heap[w_last];
                                r_heap[w_last] <= r_heap[w_tpos];
                                r_pos[r_heap[w_last]] <= w_tpos;
                            end
                            r_pos[r_heap[w_tpos]] <= '0;
                            r_cnt <= r_cnt - POS_W'(1);
                            r_p   <= w_tpos;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_ctl.set_dn) r_p <= r_pos[r_heap[r_p]];
            if ((i_ctl.up_step && w_up) || (i_ctl.dn_step && w_dn)) begin
                r_heap[r_p]   <= r_heap[w_swp];
                r_heap[w_swp] <= r_heap[r_p];
                r_pos[r_heap[r_p]]   <= w_swp;
                r_pos[r_heap[w_swp]] <= r_p;
                r_p <= w_swp;
            end
            if (i_ctl.make_rsp) begin
                r_rsp.removed_slot <= r_removed;
                r_rsp.min_slot     <= (r_cnt != '0) ? r_heap[1] : '0;
                r_rsp.min_key      <= (r_cnt != '0) ? r_key[r_heap[1]] : '0;
                r_rsp.occupancy    <= r_cnt;
                r_rsp.is_empty     <= r_cnt == '0;
                r_rsp.status       <= r_stat;
                r_rsp.slot_present <= w_pres;
                r_rsp.slot_key     <= w_pres ? r_key[r_req.slot] : '0;
            end
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= POS_W'(SLOTS)) else $error("count overflow");
    a_step_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.up_step && w_up) |=> r_p == $past(w_par)) else $error("cursor lost");
    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.up_step || i_ctl.dn_step) |=> $stable(r_cnt)) else $error("count moved");
endmodule

/* dv/imq_tb_if.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imq_tb_if
// Scoreboard package: predicts heap replies and checks them.
// ----------------------------------------------------------------------------
package imq_tb_pkg;
    import imq_pkg::*;

    // Predicts heap replies and keeps the replies still owed.
    class heap_scoreboard;
        logic signed [KEY_W-1:0] keys[SLOTS];
        int unsigned             order[SLOTS+1];
        int unsigned             place[SLOTS];
        int unsigned             count;
        t_rsp                    owed[$];
        int                      errors;

        function new();
            foreach (place[i]) place[i] = 0;
            foreach (order[i]) order[i] = 0;
            count  = 0;
            errors = 0;
        endfunction

        function logic signed [KEY_W-1:0] key_of(int unsigned p);
            return keys[order[p]];
        endfunction

        function void swap_pos(int unsigned a, int unsigned b);
            int unsigned t;
            t = order[a]; order[a] = order[b]; order[b] = t;
            place[order[a]] = a;
            place[order[b]] = b;
        endfunction

        function void raise(int unsigned p);
            while (p > 1 && p <= count && key_of(p / 2) > key_of(p)) begin
                swap_pos(p, p / 2);
                p = p / 2;
            end
        endfunction

        function void lower(int unsigned p);
            int unsigned c;
            while (p >= 1 && 2 * p <= count) begin
                c = 2 * p;
                if (c < count && key_of(c) > key_of(c + 1)) c++;
                if (key_of(p) <= key_of(c)) break;
                swap_pos(p, c);
                p = c;
            end
        endfunction

        function void pull(int unsigned p, int unsigned s);
            swap_pos(p, count);
            count--;
            place[s] = 0;
            if (p <= count) begin
                raise(p);
                lower(p);
            end
        endfunction

        function void note_request(t_req r);
            t_rsp        e;
            int unsigned s;
            bit          here;
            s    = r.slot;
            here = place[s] != 0;
            e    = '0;
            e.status = ST_OK;
            case (r.command)
                CMD_INSERT: begin
                    if (count >= SLOTS) e.status = ST_FULL;
                    else if (here) e.status = ST_PRESENT;
                    else begin
                        count++;
                        place[s] = count;
                        order[count] = s;
                        keys[s] = r.new_key;
                        raise(count);
                    end
                end
                CMD_REMOVE: begin
                    if (count == 0) e.status = ST_EMPTY;
                    else begin
                        e.removed_slot = SLOT_W'(order[1]);
                        pull(1, order[1]);
                    end
                end
                CMD_CHANGE: begin
                    if (!here) e.status = ST_ABSENT;
                    else begin
                        keys[s] = r.new_key;
                        raise(place[s]);
                        lower(place[s]);
                    end
                end
                CMD_DELETE: begin
                    if (!here) e.status = ST_ABSENT;
                    else pull(place[s], s);
                end
                default: ;
            endcase
            if (count != 0) begin
                e.min_slot = SLOT_W'(order[1]);
                e.min_key  = keys[order[1]];
            end
            e.occupancy = POS_W'(count);
            e.is_empty  = count == 0;
            if (place[s] != 0) begin
                e.slot_present = 1'b1;
                e.slot_key     = keys[s];
            end
            owed = {owed, e};
        endfunction

        function void check_reply(t_rsp a);
            t_rsp e;
            if (owed.size() == 0) begin
                $error("reply with none expected: %p", a);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (a.removed_slot !== e.removed_slot) begin
                $error("removed_slot exp %0d got %0d", e.removed_slot, a.removed_slot);
                errors++;
            end
            if (a.min_slot !== e.min_slot) begin
                $error("min_slot exp %0d got %0d", e.min_slot, a.min_slot);
                errors++;
            end
            if (a.min_key !== e.min_key) begin
                $error("min_key exp %0d got %0d", e.min_key, a.min_key);
                errors++;
            end
            if (a.occupancy !== e.occupancy) begin
                $error("occupancy exp %0d got %0d", e.occupancy, a.occupancy);
                errors++;
            end
            if (a.is_empty !== e.is_empty) begin
                $error("is_empty exp %0d got %0d", e.is_empty, a.is_empty);
                errors++;
            end
            if (a.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, a.status);
                errors++;
            end
            if (a.slot_present !== e.slot_present) begin
                $error("slot_present exp %0d got %0d", e.slot_present, a.slot_present);
                errors++;
            end
            if (a.slot_key !== e.slot_key) begin
                $error("slot_key exp %0d got %0d", e.slot_key, a.slot_key);
                errors++;
            end
        endfunction
    endclass
endpackage

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives random and directed heap commands, predicts every reply and
// compares it field by field, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
    import imq_pkg::*;
    import imq_tb_pkg::*;

    localparam int RAND_BEATS = 1800;
    localparam int HANG_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;

    imq_if #(.T(t_req)) req_ch ();
    imq_if #(.T(t_rsp)) rsp_ch ();

    indexed_min_priority_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    heap_scoreboard board;
    bit             calm;       // no idling on either side
    bit             hold_rsp;   // long receiver hold-off
    int             idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // send one command beat, with occasional idle cycles before it
    task automatic send(logic [CMD_W-1:0] c, logic [SLOT_W-1:0] s,
                        logic signed [KEY_W-1:0] k);
        t_req r;
        r.command = c;
        r.slot    = s;
        r.new_key = k;
        while (!calm && $urandom_range(99) < 7) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        board.note_request(r);
    endtask

    task automatic idle_send();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(3))
            0:       return $urandom_range(7) - 3;
            1:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [SLOT_W-1:0] pick_slot();
        // prefer present slots so change and delete reach deep into the heap
        int unsigned s;
        s = $urandom_range(SLOTS - 1);
        if (board.count != 0 && $urandom_range(3) != 0) begin
            repeat (8) begin
                if (board.place[s] != 0) break;
                s = $urandom_range(SLOTS - 1);
            end
        end
        return SLOT_W'(s);
    endfunction

    task automatic random_beat();
        int unsigned roll;
        logic [CMD_W-1:0] c;
        roll = $urandom_range(99);
        if (roll < 35)      c = CMD_INSERT;
        else if (roll < 55) c = CMD_REMOVE;
        else if (roll < 75) c = CMD_CHANGE;
        else if (roll < 90) c = CMD_DELETE;
        else                c = CMD_W'($urandom_range(7, 4));
        send(c, pick_slot(), pick_key());
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        bit held;
        held = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_rsp && !held) begin
                rsp_ch.ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                held = 1'b1;
            end
            rsp_ch.ready <= calm || $urandom_range(99) >= 7;
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready) board.check_reply(rsp_ch.data);
        end
    end

    // watchdog on cycles without any accepted beat
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= HANG_LIMIT) begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        board    = new();
        calm     = 1'b0;
        hold_rsp = 1'b0;
        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty cases, extremes, fill, overfill, then change, delete, reinsert and remove
        send(CMD_REMOVE, 4'd0, 32'sd0);
        send(CMD_CHANGE, 4'd3, 32'sd1);
        send(CMD_DELETE, 4'd15, 32'sd1);
        send(3'd4, 4'd0, 32'sd0);
        send(3'd7, 4'd9, 32'sd5);
        for (int i = 0; i < SLOTS; i++)
            send(CMD_INSERT, SLOT_W'(i),
                 (i % 3 == 0) ? 32'sh80000000 + i : 32'sh7fffffff - i);
        send(CMD_INSERT, 4'd5, 32'sd0);
        send(CMD_CHANGE, 4'd15, 32'sh80000000);
        send(CMD_DELETE, 4'd15, 32'sd0);
        send(CMD_INSERT, 4'd15, -32'sd1);
        send(CMD_INSERT, 4'd15, 32'sd2);
        send(CMD_REMOVE, 4'd0, 32'sd0);
        send(CMD_DELETE, 4'd6, 32'sd0);

        // drain, then random
        while (board.owed.size() != 0) idle_send();
        for (int n = 0; n < RAND_BEATS; n++) begin
            if (n == 300) calm = 1'b1;
            if (n == 600) calm = 1'b0;
            if (n == 900) hold_rsp = 1'b1;
            if (n == 1200) begin
                idle_send();
                while (board.owed.size() != 0) @(posedge i_clk);
            end
            random_beat();
        end
        req_ch.valid <= 1'b0;

        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
